// ----- hw/rtl/three_phase_sine_duty_generator_core_macros.svh -----
// assertion macros shared by the three-phase sine duty generator rtl
`ifndef THREE_PHASE_SINE_DUTY_GENERATOR_CORE_MACROS_SVH
`define THREE_PHASE_SINE_DUTY_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TPSDG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TPSDG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TPSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/tpsdg_pkg.sv -----
// shared constants, types and sine helper for the three-phase duty generator
`default_nettype none

package tpsdg_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int MIN_UPDATE_US_DEF   = 100;

    localparam int ELAPSED_W  = 16;
    localparam int TIME_W     = 16;
    localparam int STEP_W     = 20;
    localparam int SPACING_W  = 16;
    localparam int MOD_W      = 16;
    localparam int DUTY_W     = 16;
    localparam int PHASE_W    = 32;
    localparam int ANGLE_W    = 16;
    localparam int MAG_W      = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [STEP_W-1:0]    STEP_RST    = 20'd21475;
    localparam logic [SPACING_W-1:0] SPACING_RST = 16'd21845;
    localparam logic [MOD_W-1:0]     MOD_RST     = 16'd39322;

    localparam logic [MAG_W-1:0]  MAG_MAX  = 17'd65536;
    localparam logic [DUTY_W:0]   DUTY_MID = 17'd32768;

    localparam longint unsigned SINE_A = 102873;
    localparam longint unsigned SINE_B = 41906;
    localparam longint unsigned SINE_C = 4569;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP    = 8'd0,
        CFG_PHASE_SPACING = 8'd1,
        CFG_MODULATION    = 8'd2,
        CFG_DRIVE_ENABLE  = 8'd3
    } cfg_idx_t;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic time_ld;
        logic prod_ld;
        logic phase_en;
        logic mag_ld;
        logic term_ld;
    } stage_ld_t;

    // quarter-wave sine magnitude in q16 for a q14 position, elaboration-time only
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned t);
        longint unsigned tl;
        longint unsigned t2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned outer;
        longint unsigned s;
        tl    = longint'(t);
        t2    = (tl * tl) >> 14;
        inner = (SINE_C * t2) >> 14;
        mid   = SINE_B - inner;
        outer = SINE_A - ((mid * t2) >> 14);
        s     = (outer * tl) >> 14;
        if (s > 65536)
        begin
            s = 65536;
        end
        return MAG_W'(s);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tpsdg_if.sv -----
// handshake channel interfaces: time ticks, duty results, register writes
`default_nettype none

interface tpsdg_in_if;
    import tpsdg_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_us;
    modport source (output valid, output elapsed_us, input ready);
    modport sink (input valid, input elapsed_us, output ready);
endinterface

interface tpsdg_out_if;
    import tpsdg_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic              outputs_off;
    modport source (output valid, output duty_a, output duty_b, output duty_c,
                    output outputs_off, input ready);
    modport sink (input valid, input duty_a, input duty_b, input duty_c,
                  input outputs_off, output ready);
endinterface

interface tpsdg_cfg_if;
    import tpsdg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/three_phase_sine_duty_generator_core.sv -----
// top level of the three-phase sinusoidal duty generator
`default_nettype none
`include "three_phase_sine_duty_generator_core_macros.svh"

// three-phase sine duty generator. each tick transaction carries the microseconds
// since the last one; they add into a saturating 16-bit time accumulator. once at
// least MIN_UPDATE_US have gathered, the 32-bit phase advances by the signed step
// register times that time and one duty transaction comes out with legs a, b, c at
// phase, phase minus spacing and phase plus spacing, plus outputs_off from the
// enable register; ticks short of the threshold give no result. one tick is taken
// every clock cycle while tick ready is high; a result passes through the six-stage
// pipe (time, multiply, phase add, sine table, depth multiply, output register).
// stalls on the duty side ripple back stage by stage, so bubbles are squeezed out
// before tick ready drops. register writes are always ready and apply at once.
module three_phase_sine_duty_generator_core #(
    parameter int SINE_TABLE_BITS = tpsdg_pkg::SINE_TABLE_BITS_DEF,
    parameter int MIN_UPDATE_US   = tpsdg_pkg::MIN_UPDATE_US_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tpsdg_in_if.sink     tick,
    tpsdg_out_if.source  duty,
    tpsdg_cfg_if.sink    cfg
);
    import tpsdg_pkg::*;

    // configuration registers
    logic signed [STEP_W-1:0] step_reg;
    logic [SPACING_W-1:0]     spacing_reg;
    logic [MOD_W-1:0]         mod_reg;
    logic                     drive_en_reg;

    // stage valid flags
    logic v_time_reg;
    logic v_prod_reg;
    logic v_phase_reg;
    logic v_mag_reg;
    logic v_term_reg;
    logic out_valid_reg;

    // stage load strobes
    logic ld_time;
    logic ld_prod;
    logic ld_phase;
    logic ld_mag;
    logic ld_term;
    logic ld_out;

    logic        tick_acc;
    logic        upd;
    stage_ld_t   ld;
    logic [ANGLE_W-1:0] phase_hi;
    logic [ANGLE_W-1:0] angle_b;
    logic [ANGLE_W-1:0] angle_c;
    logic [DUTY_W-1:0]  leg_a;
    logic [DUTY_W-1:0]  leg_b;
    logic [DUTY_W-1:0]  leg_c;
    logic [DUTY_W-1:0]  duty_a_reg;
    logic [DUTY_W-1:0]  duty_b_reg;
    logic [DUTY_W-1:0]  duty_c_reg;
    logic               off_reg;

    // register write port never stalls
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_RST;
            spacing_reg  <= SPACING_RST;
            mod_reg      <= MOD_RST;
            drive_en_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PHASE_STEP:    step_reg     <= cfg.data[STEP_W-1:0];
                CFG_PHASE_SPACING: spacing_reg  <= cfg.data[SPACING_W-1:0];
                CFG_MODULATION:    mod_reg      <= cfg.data[MOD_W-1:0];
                CFG_DRIVE_ENABLE:  drive_en_reg <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on this cycle
    always_comb
    begin
        ld_out   = !out_valid_reg || duty.ready;
        ld_term  = !v_term_reg || ld_out;
        ld_mag   = !v_mag_reg || ld_term;
        ld_phase = !v_phase_reg || ld_mag;
        ld_prod  = !v_prod_reg || ld_phase;
        ld_time  = !v_time_reg || ld_prod;
    end

    assign tick.ready = ld_time;
    assign tick_acc   = tick.valid && ld_time;

    always_comb
    begin
        ld.time_ld  = ld_time;
        ld.prod_ld  = ld_prod;
        ld.phase_en = ld_phase && v_prod_reg;
        ld.mag_ld   = ld_mag;
        ld.term_ld  = ld_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_time_reg    <= 1'b0;
            v_prod_reg    <= 1'b0;
            v_phase_reg   <= 1'b0;
            v_mag_reg     <= 1'b0;
            v_term_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld_time)
            begin
                v_time_reg <= tick_acc && upd;
            end
            if (ld_prod)
            begin
                v_prod_reg <= v_time_reg;
            end
            if (ld_phase)
            begin
                v_phase_reg <= v_prod_reg;
            end
            if (ld_mag)
            begin
                v_mag_reg <= v_phase_reg;
            end
            if (ld_term)
            begin
                v_term_reg <= v_mag_reg;
            end
            if (ld_out)
            begin
                out_valid_reg <= v_term_reg;
            end
        end
    end

    tpsdg_phase #(
        .MIN_UPDATE_US (MIN_UPDATE_US)
    ) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (tick_acc),
        .elapsed_us (tick.elapsed_us),
        .phase_step (step_reg),
        .ld         (ld),
        .upd        (upd),
        .phase_hi   (phase_hi)
    );

    // leg angles wrap modulo one turn
    assign angle_b = phase_hi - spacing_reg;
    assign angle_c = phase_hi + spacing_reg;

    tpsdg_leg #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_leg_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle      (phase_hi),
        .modulation (mod_reg),
        .ld         (ld),
        .duty       (leg_a)
    );

    tpsdg_leg #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_leg_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle      (angle_b),
        .modulation (mod_reg),
        .ld         (ld),
        .duty       (leg_b)
    );

    tpsdg_leg #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_leg_c (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle      (angle_c),
        .modulation (mod_reg),
        .ld         (ld),
        .duty       (leg_c)
    );

    // output register parts the pipe from the duty consumer
    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            duty_a_reg <= leg_a;
            duty_b_reg <= leg_b;
            duty_c_reg <= leg_c;
            off_reg    <= !drive_en_reg;
        end
    end

    assign duty.valid       = out_valid_reg;
    assign duty.duty_a      = duty_a_reg;
    assign duty.duty_b      = duty_b_reg;
    assign duty.duty_c      = duty_c_reg;
    assign duty.outputs_off = off_reg;

    `TPSDG_ASSERT_SAME(a_stall_src, clk, rst_n, !tick.ready, out_valid_reg && !duty.ready, "tick stall without duty stall")
    `TPSDG_ASSERT_NEXT(a_update_enters, clk, rst_n, tick_acc && upd, v_time_reg, "update not in pipe")

endmodule

`default_nettype wire

// ----- hw/rtl/tpsdg_phase.sv -----
// time accumulator, phase increment multiply and phase accumulator
`default_nettype none
`include "three_phase_sine_duty_generator_core_macros.svh"

module tpsdg_phase #(
    parameter int MIN_UPDATE_US = tpsdg_pkg::MIN_UPDATE_US_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   acc,
    input  logic [tpsdg_pkg::ELAPSED_W-1:0]        elapsed_us,
    input  logic signed [tpsdg_pkg::STEP_W-1:0]    phase_step,
    input  tpsdg_pkg::stage_ld_t                   ld,
    output logic                                   upd,
    output logic [tpsdg_pkg::ANGLE_W-1:0]          phase_hi
);
    import tpsdg_pkg::*;

    localparam logic [TIME_W-1:0] MIN_US = TIME_W'(MIN_UPDATE_US);

    logic [TIME_W-1:0]            time_acc_reg;
    logic [TIME_W-1:0]            time_val_reg;
    logic [PHASE_W-1:0]           prod_reg;
    logic [PHASE_W-1:0]           phase_acc_reg;
    logic [TIME_W:0]              sum;
    logic [TIME_W-1:0]            sat;
    logic signed [STEP_W+TIME_W:0] prod_full;

    // saturating time sum
    always_comb
    begin
        sum = {1'b0, time_acc_reg} + {1'b0, elapsed_us};
        sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        upd = (sat >= MIN_US);
    end

    assign prod_full = phase_step * $signed({1'b0, time_val_reg});
    assign phase_hi  = phase_acc_reg[PHASE_W-1 -: ANGLE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_acc_reg  <= '0;
            phase_acc_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                time_acc_reg <= upd ? '0 : sat;
            end
            if (ld.phase_en)
            begin
                phase_acc_reg <= phase_acc_reg + prod_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.time_ld)
        begin
            time_val_reg <= sat;
        end
        if (ld.prod_ld)
        begin
            prod_reg <= prod_full[PHASE_W-1:0];
        end
    end

    `TPSDG_ASSERT_NEXT(a_time_clear, clk, rst_n, acc && upd, time_acc_reg == '0, "time not cleared")
    `TPSDG_ASSERT_NEXT(a_phase_hold, clk, rst_n, !ld.phase_en, $stable(phase_acc_reg), "phase moved")

endmodule

`default_nettype wire

// ----- hw/rtl/tpsdg_leg.sv -----
// one output leg: sine table lookup, depth scaling and duty offset
`default_nettype none
`include "three_phase_sine_duty_generator_core_macros.svh"

module tpsdg_leg #(
    parameter int SINE_TABLE_BITS = tpsdg_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tpsdg_pkg::ANGLE_W-1:0]    angle,
    input  logic [tpsdg_pkg::MOD_W-1:0]      modulation,
    input  tpsdg_pkg::stage_ld_t             ld,
    output logic [tpsdg_pkg::DUTY_W-1:0]     duty
);
    import tpsdg_pkg::*;

    localparam int SH    = ANGLE_W - SINE_TABLE_BITS;
    localparam int QB    = SINE_TABLE_BITS - 2;
    localparam int LUT_N = (1 << QB) + 1;
    localparam int SC_W  = MOD_W + MAG_W + 1;
    localparam logic [QB:0] QFULL = {1'b1, {QB{1'b0}}};

    logic [MAG_W-1:0]  lut [LUT_N];
    logic [1:0]        quad;
    logic [QB-1:0]     low;
    logic [QB:0]       idx;
    logic [MAG_W-1:0]  mag_reg;
    logic              mag_neg_reg;
    logic [SC_W-1:0]   scaled;
    logic [DUTY_W-1:0] term_reg;
    logic              term_neg_reg;
    logic [DUTY_W:0]   dsum;

    // quarter-wave table, entries at the table step
    for (genvar i = 0; i < LUT_N; i++)
    begin : g_lut
        assign lut[i] = sine_mag(i * (1 << SH));
    end

    always_comb
    begin
        quad = angle[ANGLE_W-1 -: 2];
        low  = angle[ANGLE_W-3:SH];
        idx  = quad[0] ? (QFULL - {1'b0, low}) : {1'b0, low};
    end

    assign scaled = SC_W'(modulation) * SC_W'(mag_reg) + SC_W'(MAG_MAX);

    always_ff @(posedge clk)
    begin
        if (ld.mag_ld)
        begin
            mag_reg     <= lut[idx];
            mag_neg_reg <= quad[1];
        end
        if (ld.term_ld)
        begin
            term_reg     <= scaled[MAG_W +: DUTY_W];
            term_neg_reg <= mag_neg_reg;
        end
    end

    // offset around mid-scale, clip the single overflow code
    always_comb
    begin
        dsum = term_neg_reg ? (DUTY_MID - {1'b0, term_reg}) : (DUTY_MID + {1'b0, term_reg});
        duty = dsum[DUTY_W] ? {DUTY_W{1'b1}} : dsum[DUTY_W-1:0];
    end

    `TPSDG_ASSERT_NEXT(a_mag_range, clk, rst_n, ld.mag_ld, mag_reg <= MAG_MAX, "sine over one")

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the three-phase sine duty generator core
`timescale 1ns / 1ps

module testbench;
    import tpsdg_pkg::*;

    // ------------------------------------------------------------------
    // run constants
    // ------------------------------------------------------------------
    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 12;    // pipe is 6 deep, leave margin
    localparam int TAIL_CYCLES     = 24;
    localparam int STALL_LIMIT     = 3000;  // cycles with no transaction at all
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 210;

    // behavior of the block as built
    localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;
    localparam int UPDATE_US  = MIN_UPDATE_US_DEF;
    localparam int ANGLE_DROP = (16 - TABLE_BITS) & 15;

    // quarter-wave polynomial coefficients, q16
    localparam longint unsigned CURVE_K1 = 102873;
    localparam longint unsigned CURVE_K3 = 41906;
    localparam longint unsigned CURVE_K5 = 4569;

    // legal register ranges
    localparam int STEP_LIMIT  = 429497;
    localparam int SPACING_LO  = 5461;
    localparam int SPACING_HI  = 32768;
    localparam int DEPTH_LIMIT = 58982;

    // register indexes that decode to nothing, and the filler index of tick rows
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'hFF;
    localparam logic [CFG_IDX_W-1:0] NO_INDEX     = '0;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic              outputs_off;
    } duty_set_t;

    // phase at zero step with 90 degree spacing and full depth: center, floor, ceiling
    localparam duty_set_t SWING_FULL = '{16'd32768, 16'd0, 16'd65535, 1'b0};
    // zero depth with the bridge shut down
    localparam duty_set_t FLAT_OFF   = '{16'd32768, 16'd32768, 16'd32768, 1'b1};
    localparam duty_set_t NO_DUTY    = '0;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed;
        duty_set_t             want;
    } script_row_t;

    localparam int SCRIPT_LEN = 38;

    // directed opening: rows with typed expectations bypass the duty model
    script_row_t script [SCRIPT_LEN] = '{
        // reset settings, threshold reached over two ticks
        '{ROW_TICK,  NO_INDEX,          20'd60,       1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd40,       1'b0, NO_DUTY},
        // freeze the phase, legs at 90 degrees, full depth
        '{ROW_WRITE, CFG_PHASE_STEP,    20'd0,        1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_PHASE_SPACING, 20'd16384,    1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_MODULATION,    20'd65535,    1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_DRIVE_ENABLE,  20'd1,        1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd100,      1'b1, SWING_FULL},
        // one short of the threshold, then exactly on it
        '{ROW_TICK,  NO_INDEX,          20'd50,       1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd49,       1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd1,        1'b1, SWING_FULL},
        '{ROW_TICK,  NO_INDEX,          20'd0,        1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd65535,    1'b1, SWING_FULL},
        // time accumulator saturates
        '{ROW_TICK,  NO_INDEX,          20'd99,       1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd65535,    1'b1, SWING_FULL},
        // writes to unused indexes must change nothing
        '{ROW_WRITE, CFG_SPARE_LO,      20'h80000,    1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_SPARE_HI,      20'h00000,    1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd100,      1'b1, SWING_FULL},
        // zero depth, drive off
        '{ROW_WRITE, CFG_MODULATION,    20'd0,        1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_DRIVE_ENABLE,  20'd0,        1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd100,      1'b1, FLAT_OFF},
        // most positive step, zero spacing, top legal depth
        '{ROW_WRITE, CFG_PHASE_STEP,    20'h7FFFF,    1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_PHASE_SPACING, 20'd0,        1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_MODULATION,    20'd58982,    1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_DRIVE_ENABLE,  20'd1,        1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd65535,    1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd100,      1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd37,       1'b0, NO_DUTY},
        // most negative step, spacing wraps past one turn
        '{ROW_WRITE, CFG_PHASE_STEP,    20'h80000,    1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_PHASE_SPACING, 20'h0FFFF,    1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd65535,    1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd1000,     1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd200,      1'b0, NO_DUTY},
        // spacing at its legal extremes, lowest legal step
        '{ROW_WRITE, CFG_PHASE_SPACING, 20'd32768,    1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd300,      1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_PHASE_SPACING, 20'd5461,     1'b0, NO_DUTY},
        '{ROW_WRITE, CFG_PHASE_STEP,    20'(-STEP_LIMIT), 1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd100,      1'b0, NO_DUTY},
        '{ROW_TICK,  NO_INDEX,          20'd150,      1'b0, NO_DUTY}
    };

    // ------------------------------------------------------------------
    // clock, reset, channels, block under test
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #(CLK_PERIOD / 2) clk = ~clk;

    tpsdg_in_if  tick_ch ();
    tpsdg_out_if duty_ch ();
    tpsdg_cfg_if cfg_ch ();

    three_phase_sine_duty_generator_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .duty  (duty_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // shared state between stimulus, duty model and checker
    // ------------------------------------------------------------------
    duty_set_t   pending_duties [$];   // duty transactions still owed by the block
    int unsigned mismatches;
    logic        typed_armed;          // current tick carries a typed expectation
    duty_set_t   typed_duty;
    logic        calm;                 // last part of the run: no stalls on the duty side

    // model copy of registers and accumulators
    logic signed [STEP_W-1:0] step_reg;
    logic [SPACING_W-1:0]     spacing_reg;
    logic [MOD_W-1:0]         depth_reg;
    logic                     enable_reg;
    logic [PHASE_W-1:0]       phase_now;
    logic [TIME_W-1:0]        time_held;

    // ------------------------------------------------------------------
    // duty model
    // ------------------------------------------------------------------

    // duty of one leg: table angle snapped to the table grid, polynomial sine, depth scaling
    function automatic logic [DUTY_W-1:0] leg_duty(input logic [ANGLE_W-1:0] angle,
                                                   input logic [MOD_W-1:0] depth);
        logic [ANGLE_W-1:0] snapped;
        logic [1:0]         quadrant;
        longint unsigned    pos;
        longint unsigned    pos_sq;
        longint unsigned    k5_term;
        longint unsigned    k3_term;
        longint unsigned    k1_term;
        longint unsigned    height;
        longint unsigned    swing;
        longint unsigned    level;
        snapped  = (angle >> ANGLE_DROP) << ANGLE_DROP;
        quadrant = snapped[15:14];
        pos      = longint'(snapped[13:0]);
        // odd quadrants run the quarter wave backwards
        if (quadrant[0])
        begin
            pos = 16384 - pos;
        end
        pos_sq  = (pos * pos) >> 14;
        k5_term = (CURVE_K5 * pos_sq) >> 14;
        k3_term = CURVE_K3 - k5_term;
        k1_term = CURVE_K1 - ((k3_term * pos_sq) >> 14);
        height  = (k1_term * pos) >> 14;
        if (height > 65536)
        begin
            height = 65536;
        end
        swing = (longint'(depth) * height + 65536) >> 17;
        level = quadrant[1] ? (32768 - swing) : (32768 + swing);
        // full positive swing lands on 65536, one past the field
        if (level > 65535)
        begin
            level = 65535;
        end
        return DUTY_W'(level);
    endfunction

    // one accepted tick: gather time, advance phase on threshold, produce the duty set
    task automatic advance_phase(input logic [ELAPSED_W-1:0] elapsed, output logic fired,
                                 output duty_set_t result);
        logic [TIME_W:0]          sum;
        logic signed [36:0]       advance;
        logic [ANGLE_W-1:0]       angle;
        sum       = {1'b0, time_held} + {1'b0, elapsed};
        time_held = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        fired     = (time_held >= UPDATE_US);
        result    = '0;
        if (fired)
        begin
            // signed step times gathered time, wraps at one turn
            advance   = step_reg * $signed({1'b0, time_held});
            phase_now = phase_now + advance[PHASE_W-1:0];
            time_held = '0;
            angle     = phase_now[PHASE_W-1:PHASE_W-ANGLE_W];
            result.duty_a      = leg_duty(angle, depth_reg);
            result.duty_b      = leg_duty(angle - spacing_reg, depth_reg);
            result.duty_c      = leg_duty(angle + spacing_reg, depth_reg);
            result.outputs_off = !enable_reg;
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: checks duty transactions, tracks register writes and ticks
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : track_and_check
        duty_set_t got;
        duty_set_t want;
        duty_set_t calc;
        logic      fired;
        if (!rst_n)
        begin
            step_reg    = STEP_RST;
            spacing_reg = SPACING_RST;
            depth_reg   = MOD_RST;
            enable_reg  = 1'b0;
            phase_now   = '0;
            time_held   = '0;
            mismatches  = 0;
            pending_duties.delete();
        end
        else
        begin
            // compare the oldest owed duty set against what came out
            if (duty_ch.valid && duty_ch.ready)
            begin
                got = '{duty_ch.duty_a, duty_ch.duty_b, duty_ch.duty_c, duty_ch.outputs_off};
                if (pending_duties.size() == 0)
                begin
                    $display("%0t ns: duty transaction, expected none, actual a=%0d b=%0d c=%0d off=%0d",
                             $time, got.duty_a, got.duty_b, got.duty_c, got.outputs_off);
                    mismatches++;
                end
                else
                begin
                    want = pending_duties.pop_front();
                    compare_field("duty_a", want.duty_a, got.duty_a);
                    compare_field("duty_b", want.duty_b, got.duty_b);
                    compare_field("duty_c", want.duty_c, got.duty_c);
                    compare_field("outputs_off", want.outputs_off, got.outputs_off);
                end
            end
            // register writes land at once; unused indexes fall through
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_PHASE_STEP:    step_reg    = cfg_ch.data[STEP_W-1:0];
                    CFG_PHASE_SPACING: spacing_reg = cfg_ch.data[SPACING_W-1:0];
                    CFG_MODULATION:    depth_reg   = cfg_ch.data[MOD_W-1:0];
                    CFG_DRIVE_ENABLE:  enable_reg  = cfg_ch.data[0];
                    default: ;
                endcase
            end
            // a tick always moves the model; typed rows supply their own expectation
            if (tick_ch.valid && tick_ch.ready)
            begin
                advance_phase(tick_ch.elapsed_us, fired, calc);
                if (typed_armed)
                begin
                    pending_duties.push_back(typed_duty);
                end
                else if (fired)
                begin
                    pending_duties.push_back(calc);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends a run that stops moving
    // ------------------------------------------------------------------
    int unsigned quiet_cycles;

    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (tick_ch.valid && tick_ch.ready) ||
            (duty_ch.valid && duty_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // duty side: ready in random runs, broken by random stall bursts
    // ------------------------------------------------------------------
    initial
    begin : duty_pacing
        int   hold;
        logic stalled;
        hold    = 0;
        stalled = 1'b0;
        duty_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // a stall burst still running ends as soon as the final stretch starts
            if (hold == 0 || (calm && stalled))
            begin
                stalled = !calm && ($urandom_range(0, 3) == 0);
                hold    = stalled ? $urandom_range(1, 11) : $urandom_range(1, 48);
            end
            hold = hold - 1;
            duty_ch.ready <= !stalled;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one tick transaction; returns at the edge it is taken
    task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed, input logic typed,
                             input duty_set_t want);
        tick_ch.valid      <= 1'b1;
        tick_ch.elapsed_us <= elapsed;
        typed_armed        <= typed;
        typed_duty         <= want;
        do @(posedge clk); while (!tick_ch.ready);
    endtask

    task automatic hold_ticks(input int cycles);
        tick_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop ticks, let every owed duty set drain, then idle for a settle margin
    task automatic settle_block();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_duties.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the channel goes idle after it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // new settings for a phase of the random run, extremes weighted in
    task automatic pick_settings();
        logic [STEP_W-1:0]    step;
        logic [SPACING_W-1:0] spacing;
        logic [MOD_W-1:0]     depth;
        case ($urandom_range(0, 6))
            0:       step = STEP_W'(STEP_LIMIT);
            1:       step = STEP_W'(-STEP_LIMIT);
            2:       step = STEP_W'($urandom);
            3:       step = STEP_W'($urandom_range(0, 2000));
            default: step = STEP_W'(int'($urandom_range(0, 2 * STEP_LIMIT)) - STEP_LIMIT);
        endcase
        case ($urandom_range(0, 5))
            0:       spacing = SPACING_W'(SPACING_LO);
            1:       spacing = SPACING_W'(SPACING_HI);
            2:       spacing = SPACING_W'($urandom);
            default: spacing = SPACING_W'($urandom_range(SPACING_LO, SPACING_HI));
        endcase
        case ($urandom_range(0, 6))
            0:       depth = '0;
            1:       depth = MOD_W'(DEPTH_LIMIT);
            2:       depth = '1;
            3:       depth = MOD_W'($urandom);
            default: depth = MOD_W'($urandom_range(0, DEPTH_LIMIT));
        endcase
        // bits above the spacing, depth and enable fields are ignored, so toggle them too
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_PHASE_SPACING, {4'($urandom), spacing});
        write_reg(CFG_MODULATION, {4'($urandom), depth});
        write_reg(CFG_DRIVE_ENABLE, CFG_DATA_W'($urandom));
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                      CFG_DATA_W'($urandom));
        end
    endtask

    // mostly short ticks that build up to an update, some around the threshold, some huge
    function automatic logic [ELAPSED_W-1:0] draw_elapsed();
        case ($urandom_range(0, 19))
            0, 1, 2:    return ELAPSED_W'($urandom);
            3, 4, 5:    return ELAPSED_W'($urandom_range(UPDATE_US, 3000));
            6, 7, 8, 9: return ELAPSED_W'($urandom_range(UPDATE_US - 10, UPDATE_US + 10));
            default:    return ELAPSED_W'($urandom_range(0, 45));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned gap_odds;
        logic        last_part;
        rst_n              <= 1'b0;
        tick_ch.valid      <= 1'b0;
        tick_ch.elapsed_us <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        typed_armed        <= 1'b0;
        typed_duty         <= '0;
        calm               <= 1'b0;
        last_part          = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening; writes only once the block has gone quiet
        foreach (script[r])
        begin
            if (script[r].kind == ROW_WRITE)
            begin
                settle_block();
                write_reg(script[r].index, script[r].value);
            end
            else
            begin
                send_tick(script[r].value[ELAPSED_W-1:0], script[r].typed, script[r].want);
            end
        end

        // random run in phases, fresh settings between phases
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            if (phase == PHASES - 1)
            begin
                // final stretch runs flat out on both sides
                last_part = 1'b1;
                calm <= 1'b1;
            end
            pick_settings();
            // every third phase sends back to back
            gap_odds = (phase % 3 == 2) ? 0 : $urandom_range(3, 12);
            for (int item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                // in phase 1, hold off midway until the block has handed back everything it owes
                if (phase == 1 && item == ITEMS_PER_PHASE / 2)
                begin
                    settle_block();
                end
                if (!last_part && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                begin
                    hold_ticks($urandom_range(1, 11));
                end
                send_tick(draw_elapsed(), 1'b0, NO_DUTY);
            end
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_duties.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tpsdg_pkg.sv
hw/rtl/tpsdg_if.sv
hw/rtl/tpsdg_phase.sv
hw/rtl/tpsdg_leg.sv
hw/rtl/three_phase_sine_duty_generator_core.sv
tb/testbench.sv
